// ===== hw/rtl/gha_pkg.sv =====
// Shared constants, request and status codes, and types for the generational
// handle allocator. No dependencies; every other file in hw/rtl imports it.
package gha_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int GEN_W    = 16;
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 2;

	// Stream payload: fields packed from bit 0 up, padded to whole bytes
	localparam int FIELD_BITS = REQ_W + IDX_W + GEN_W;
	localparam int DATA_W     = ((FIELD_BITS + 7) / 8) * 8;
	localparam int PAD_W      = DATA_W - FIELD_BITS;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEALLOC = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	// One slot entry: live flag and current generation
	typedef struct packed {
		logic             live;
		logic [GEN_W-1:0] gen;
	} slot_t;

	// One free-stack entry: the freed slot and its generation at free time
	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [IDX_W-1:0] slot;
	} stack_t;

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture request, issue memory reads
		logic exec;   // resolve request, write back, load output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_valid;
	} dp_stat_t;

endpackage

// ===== hw/rtl/gha_ctrl.sv =====
// Controller for the handle allocator: two-state sequencer that accepts an
// item, then resolves it once the output register can take the result.
// Depends on gha_pkg.
module gha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              m_tready,
	input  gha_pkg::dp_stat_t stat,
	output gha_pkg::dp_cmd_t  cmd
);
	import gha_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	assign s_tready = (state_q == ST_IDLE);
	assign cmd.load = s_tready && s_tvalid;
	// Hold in EXEC while a previous result is still waiting downstream
	assign cmd.exec = (state_q == ST_EXEC) && (!stat.out_valid || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd.exec) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/gha_datapath.sv =====
// Datapath for the handle allocator: slot memory, free-slot stack memory,
// counters and the output register. Driven by gha_ctrl; depends on gha_pkg.
module gha_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gha_pkg::dp_cmd_t           cmd,
	input  logic [gha_pkg::DATA_W-1:0] s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [gha_pkg::DATA_W-1:0] m_tdata,
	output gha_pkg::dp_stat_t          stat
);
	import gha_pkg::*;

	// Request fields from the stream
	logic [REQ_W-1:0] in_req;
	logic [IDX_W-1:0] in_idx;
	logic [GEN_W-1:0] in_gen;

	assign in_req = s_tdata[REQ_W-1:0];
	assign in_idx = s_tdata[REQ_W +: IDX_W];
	assign in_gen = s_tdata[REQ_W+IDX_W +: GEN_W];

	// Captured request
	logic [REQ_W-1:0] req_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;

	// Memories and their registered read data
	slot_t  slot_mem  [CAPACITY];
	stack_t stack_mem [CAPACITY];
	slot_t  slot_rd_q;
	stack_t stack_rd_q;

	// Counters
	logic [CNT_W-1:0] free_cnt_q;
	logic [CNT_W-1:0] created_q;
	logic [CNT_W-1:0] free_cnt_d;
	logic [CNT_W-1:0] created_d;

	logic [IDX_W-1:0] stack_top;

	// Write ports and result
	logic             slot_we;
	logic [IDX_W-1:0] slot_wa;
	slot_t            slot_wd;
	logic             stack_we;
	logic [IDX_W-1:0] stack_wa;
	stack_t           stack_wd;
	logic [STAT_W-1:0] res_stat;
	logic [IDX_W-1:0]  res_idx;
	logic [GEN_W-1:0]  res_gen;
	logic              current;

	logic                m_tvalid_q;
	logic [DATA_W-1:0]   m_tdata_q;

	assign stack_top = free_cnt_q[IDX_W-1:0] - IDX_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= in_req;
			idx_q      <= in_idx;
			gen_q      <= in_gen;
			slot_rd_q  <= slot_mem[in_idx];
			stack_rd_q <= stack_mem[stack_top];
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (stack_we) begin
			stack_mem[stack_wa] <= stack_wd;
		end
	end

	assign current = ({1'b0, idx_q} < created_q) && slot_rd_q.live &&
	                 (slot_rd_q.gen == gen_q);

	always_comb begin
		slot_we    = 1'b0;
		slot_wa    = idx_q;
		slot_wd    = slot_rd_q;
		stack_we   = 1'b0;
		stack_wa   = free_cnt_q[IDX_W-1:0];
		stack_wd   = '{gen: slot_rd_q.gen, slot: idx_q};
		res_stat   = STAT_OK;
		res_idx    = '0;
		res_gen    = '0;
		free_cnt_d = free_cnt_q;
		created_d  = created_q;
		case (req_q)
			REQ_ALLOC: begin
				if (free_cnt_q != '0) begin
					// Reuse the most recently freed slot, next generation
					slot_we    = cmd.exec;
					slot_wa    = stack_rd_q.slot;
					slot_wd    = '{live: 1'b1, gen: stack_rd_q.gen + GEN_W'(1)};
					res_idx    = stack_rd_q.slot;
					res_gen    = stack_rd_q.gen + GEN_W'(1);
					free_cnt_d = free_cnt_q - CNT_W'(1);
				end else if (created_q < CAP_COUNT) begin
					// Create a fresh slot at generation zero
					slot_we   = cmd.exec;
					slot_wa   = created_q[IDX_W-1:0];
					slot_wd   = '{live: 1'b1, gen: '0};
					res_idx   = created_q[IDX_W-1:0];
					created_d = created_q + CNT_W'(1);
				end else begin
					res_stat = STAT_FULL;
				end
			end
			REQ_DEALLOC: begin
				if (current) begin
					slot_we = cmd.exec;
					slot_wd = '{live: 1'b0, gen: slot_rd_q.gen};
					if (free_cnt_q < CAP_COUNT) begin
						stack_we   = cmd.exec;
						free_cnt_d = free_cnt_q + CNT_W'(1);
					end
				end else begin
					res_stat = STAT_REJECT;
				end
			end
			REQ_CHECK: begin
				res_stat = current ? STAT_OK : STAT_REJECT;
			end
			REQ_CLEAR: begin
				free_cnt_d = '0;
				created_d  = '0;
			end
			default: begin
				res_stat = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
			created_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				free_cnt_q <= free_cnt_d;
				created_q  <= created_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			m_tdata_q <= {{PAD_W{1'b0}}, res_gen, res_idx, res_stat};
		end
	end

	assign m_tvalid       = m_tvalid_q;
	assign m_tdata        = m_tdata_q;
	assign stat.out_valid = m_tvalid_q;

endmodule

// ===== hw/rtl/generational_handle_allocator.sv =====
// Top level of the generational handle allocator: joins the sequencer
// (gha_ctrl) and the memories and counters (gha_datapath). Depends on gha_pkg.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  req_type, handle_index, handle_generation
//  m_*       out  m_tvalid/m_tready  status, out_index, out_generation
//
// Each item is accepted, then resolved: the accept edge captures the request
// and reads the slot memory and the top of the free stack; the resolve edge
// writes the memories back as the request needs and loads the output register,
// after the synchronous read. A new item is accepted while a finished result
// still waits in the output register; resolution then holds until that result
// is taken. Reset clears only the counters and the handshake state; read data
// is used only from memory entries written since the last clear or reset.
module generational_handle_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	// s_tdata: req_type[1:0], handle_index[11:2], handle_generation[27:12], pad
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [gha_pkg::DATA_W-1:0] s_tdata,
	// m_tdata: status[1:0], out_index[11:2], out_generation[27:12], pad
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [gha_pkg::DATA_W-1:0] m_tdata
);
	import gha_pkg::*;

	// Command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gha_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.stat     (stat)
	);

endmodule

// ===== hw/rtl/gha_checker.sv =====
// Port-level checks for the generational handle allocator, bound to the top
// level. Depends on gha_pkg and generational_handle_allocator.
module gha_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [gha_pkg::DATA_W-1:0] s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [gha_pkg::DATA_W-1:0] m_tdata
);
	import gha_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One item at a time: no accept right after an accept
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted in consecutive cycles");

	// Only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[STAT_W-1:0] == STAT_OK) ||
		             (m_tdata[STAT_W-1:0] == STAT_REJECT) ||
		             (m_tdata[STAT_W-1:0] == STAT_FULL))
		else $error("undefined status code");

	// Rejected or full results carry a zero handle and zero padding
	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[STAT_W-1:0] != STAT_OK) |->
		m_tdata[DATA_W-1:STAT_W] == '0)
		else $error("nonzero handle on failed request");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/generational_handle_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_allocator: a directed table, a fill to
// capacity and random traffic, scored against a local allocator model or hand-typed replies.
// Depends on gha_pkg and the allocator RTL.
module generational_handle_allocator_tb;
	import gha_pkg::*;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  idx;
		logic [GEN_W-1:0]  gen;
	} reply_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
	} handle_t;

	// One directed row: the request, and a reply typed in by hand where it is obvious
	typedef struct {
		request_t rq;
		bit       typed;
		reply_t   rp;
	} vector_t;

	localparam int N_DIRECTED = 23;
	localparam int SEEN_MAX   = 64;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // req_type, handle_index, handle_generation, pad
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // status, out_index, out_generation, pad

	// Shadow copy of the allocator: per-slot live flag and generation, LIFO of freed slots
	bit               slot_live [CAPACITY];
	logic [GEN_W-1:0] slot_gen  [CAPACITY];
	logic [IDX_W-1:0] freed_slots [$];
	int               slots_made;

	reply_t  replies_due  [$];   // predicted replies, oldest first
	handle_t handles_seen [$];   // recently issued handles, live or stale
	int      errors;
	bit      rx_stalls;

	vector_t directed_rows [N_DIRECTED] = '{
		// nothing created yet: every handle is rejected
		'{request_t'{REQ_CHECK,   10'd0,    16'd0},     1'b1, reply_t'{STAT_REJECT, '0, '0}},
		'{request_t'{REQ_DEALLOC, 10'd1023, 16'd65535}, 1'b1, reply_t'{STAT_REJECT, '0, '0}},
		// allocate ignores the handle fields; fresh slots start at generation zero
		'{request_t'{REQ_ALLOC,   10'd1023, 16'd65535}, 1'b1, reply_t'{STAT_OK, 10'd0, 16'd0}},
		'{request_t'{REQ_ALLOC,   10'd0,    16'd0},     1'b1, reply_t'{STAT_OK, 10'd1, 16'd0}},
		'{request_t'{REQ_CHECK,   10'd0,    16'd0},     1'b1, reply_t'{STAT_OK, '0, '0}},
		// wrong generation, then an index never created
		'{request_t'{REQ_CHECK,   10'd1,    16'd1},     1'b1, reply_t'{STAT_REJECT, '0, '0}},
		'{request_t'{REQ_CHECK,   10'd2,    16'd0},     1'b1, reply_t'{STAT_REJECT, '0, '0}},
		// free once, then the same handle again is rejected
		'{request_t'{REQ_DEALLOC, 10'd0,    16'd0},     1'b1, reply_t'{STAT_OK, '0, '0}},
		'{request_t'{REQ_DEALLOC, 10'd0,    16'd0},     1'b1, reply_t'{STAT_REJECT, '0, '0}},
		'{request_t'{REQ_CHECK,   10'd0,    16'd0},     1'b1, reply_t'{STAT_REJECT, '0, '0}},
		// reuse bumps the generation; the old handle is stale
		'{request_t'{REQ_ALLOC,   10'd0,    16'd0},     1'b0, reply_t'('0)},
		'{request_t'{REQ_DEALLOC, 10'd0,    16'd0},     1'b0, reply_t'('0)},
		'{request_t'{REQ_DEALLOC, 10'd1,    16'd0},     1'b0, reply_t'('0)},
		'{request_t'{REQ_DEALLOC, 10'd0,    16'd1},     1'b0, reply_t'('0)},
		// LIFO order of reuse, then a new slot once the stack is empty
		'{request_t'{REQ_ALLOC,   10'd0,    16'd0},     1'b0, reply_t'('0)},
		'{request_t'{REQ_ALLOC,   10'd0,    16'd0},     1'b0, reply_t'('0)},
		'{request_t'{REQ_ALLOC,   10'd0,    16'd0},     1'b0, reply_t'('0)},
		'{request_t'{REQ_CHECK,   10'd1,    16'd1},     1'b0, reply_t'('0)},
		// clear forgets every slot, whatever its handle fields carry
		'{request_t'{REQ_CLEAR,   10'd1023, 16'd65535}, 1'b1, reply_t'{STAT_OK, '0, '0}},
		'{request_t'{REQ_CHECK,   10'd0,    16'd2},     1'b1, reply_t'{STAT_REJECT, '0, '0}},
		'{request_t'{REQ_ALLOC,   10'd0,    16'd0},     1'b1, reply_t'{STAT_OK, 10'd0, 16'd0}},
		'{request_t'{REQ_CHECK,   10'd0,    16'd0},     1'b0, reply_t'('0)},
		'{request_t'{REQ_CHECK,   10'd1023, 16'd0},     1'b0, reply_t'('0)}
	};

	generational_handle_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run
	initial begin
		#(50_000_000);
		$display("TB_ERROR");
		$finish;
	end

	// A handle is current when its slot exists, is live and carries the same generation
	function automatic bit handle_current(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
		return int'(idx) < slots_made && slot_live[idx] && slot_gen[idx] == gen;
	endfunction

	// Apply one request to the shadow state and return the reply it must produce
	function automatic reply_t allocator_step(request_t rq);
		reply_t           rp;
		logic [IDX_W-1:0] slot;
		rp = '0;
		case (rq.req)
		REQ_ALLOC: begin
			if (freed_slots.size() > 0) begin
				// reuse the most recently freed slot, generation wraps naturally
				slot = freed_slots.pop_back();
				slot_gen[slot] = slot_gen[slot] + 1'b1;
				slot_live[slot] = 1'b1;
				rp.idx = slot;
				rp.gen = slot_gen[slot];
			end else if (slots_made < CAPACITY) begin
				slot = IDX_W'(slots_made);
				slot_gen[slot] = '0;
				slot_live[slot] = 1'b1;
				slots_made++;
				rp.idx = slot;
			end else begin
				rp.status = STAT_FULL;
			end
		end
		REQ_DEALLOC: begin
			if (handle_current(rq.idx, rq.gen)) begin
				slot_live[rq.idx] = 1'b0;
				freed_slots.push_back(rq.idx);
			end else begin
				rp.status = STAT_REJECT;
			end
		end
		REQ_CHECK: begin
			rp.status = handle_current(rq.idx, rq.gen) ? STAT_OK : STAT_REJECT;
		end
		default: begin
			freed_slots.delete();
			slots_made = 0;
		end
		endcase
		return rp;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
	endfunction

	// Mostly well-formed traffic on handles already issued, some stale, some noise
	function automatic request_t random_request();
		request_t rq;
		handle_t  h;
		int       pick;
		rq.req = REQ_ALLOC;
		rq.idx = IDX_W'($urandom);
		rq.gen = GEN_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			rq.req = REQ_ALLOC;
		end else if (pick < 93 && handles_seen.size() > 0) begin
			h = handles_seen[$urandom_range(0, handles_seen.size() - 1)];
			rq.req = ($urandom_range(0, 1) != 0) ? REQ_DEALLOC : REQ_CHECK;
			rq.idx = h.idx;
			rq.gen = h.gen;
			// bend the handle now and then: wrong generation or a slot index up to the count created
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1) != 0)
					rq.gen = h.gen + GEN_W'($urandom_range(1, 3));
				else
					rq.idx = IDX_W'($urandom_range(0, slots_made));
			end
		end else if (pick < 99) begin
			rq.req = ($urandom_range(0, 1) != 0) ? REQ_DEALLOC : REQ_CHECK;
		end else begin
			rq.req = REQ_CLEAR;
		end
		return rq;
	endfunction

	// Present one item from the falling edge and hold it until accepted; leave valid high
	task automatic send_req(input request_t rq, input bit typed = 1'b0,
			input reply_t want = '0);
		reply_t rp;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {{PAD_W{1'b0}}, rq.gen, rq.idx, rq.req};
		do @(posedge clk); while (!s_tready);
		rp = allocator_step(rq);
		replies_due.push_back(typed ? want : rp);
		if (rq.req == REQ_CLEAR)
			handles_seen.delete();
		else if (rq.req == REQ_ALLOC && rp.status == STAT_OK) begin
			handles_seen.push_back(handle_t'{rp.idx, rp.gen});
			if (handles_seen.size() > SEEN_MAX)
				handles_seen.delete(0);
		end
	endtask

	task automatic sender_pause(input int n);
		@(negedge clk);
		s_tvalid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Drop valid and hold off until every predicted reply has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	// Result side: ready toggles from the falling edge, with random stalls when enabled
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				if (rx_stalls && $urandom_range(0, 5) == 0)
					hold = gap_len();
			end
		end
	end

	// Score every accepted result against the oldest prediction
	initial begin
		reply_t got;
		reply_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.status = m_tdata[STAT_W-1:0];
				got.idx    = m_tdata[STAT_W +: IDX_W];
				got.gen    = m_tdata[STAT_W + IDX_W +: GEN_W];
				if (replies_due.size() == 0) begin
					$error("unexpected result: status %0d, out_index %0d, out_generation %0d",
						got.status, got.idx, got.gen);
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						errors++;
					end
					if (got.idx !== want.idx) begin
						$error("out_index: expected %0d, actual %0d", want.idx, got.idx);
						errors++;
					end
					if (got.gen !== want.gen) begin
						$error("out_generation: expected %0d, actual %0d", want.gen, got.gen);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int sent;
		int n;
		bit tx_gaps;
		errors     = 0;
		slots_made = 0;
		rx_stalls  = 1'b1;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		foreach (directed_rows[i]) begin
			if ($urandom_range(0, 2) == 0)
				sender_pause(gap_len());
			send_req(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].rp);
		end

		// Fill every slot, hit the full table, then free and reuse at capacity
		wait_drained();
		send_req(request_t'{REQ_CLEAR, '0, '0});
		repeat (CAPACITY) begin
			if ($urandom_range(0, 7) == 0)
				sender_pause(gap_len());
			send_req(request_t'{REQ_ALLOC, IDX_W'($urandom), GEN_W'($urandom)});
		end
		repeat (2)
			send_req(request_t'{REQ_ALLOC, '1, '1}, 1'b1, reply_t'{STAT_FULL, '0, '0});
		send_req(request_t'{REQ_DEALLOC, IDX_W'(CAPACITY - 1), '0});
		send_req(request_t'{REQ_DEALLOC, IDX_W'(CAPACITY / 2), '0});
		repeat (3)
			send_req(request_t'{REQ_ALLOC, '0, '0});
		send_req(request_t'{REQ_CHECK, IDX_W'(CAPACITY - 1), GEN_W'(1)});
		wait_drained();
		send_req(request_t'{REQ_CLEAR, '0, '0});

		// Random traffic in bursts, each with its own idling mix
		sent = 0;
		while (sent < 300) begin
			tx_gaps   = $urandom_range(0, 3) != 0;
			rx_stalls = $urandom_range(0, 3) != 0;
			n = $urandom_range(40, 120);
			repeat (n) begin
				if (tx_gaps && $urandom_range(0, 3) == 0)
					sender_pause(gap_len());
				send_req(random_request());
			end
			sent += n;
			if ($urandom_range(0, 2) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
